// ===== hdl/rdtb_pkg.sv =====
// rdtb_pkg: constants, register map codes and shared types of the reload down-timer bank
// used by rdtb_timer and reload_down_timer_bank; no dependencies
`default_nettype none

package rdtb_pkg;

	// bank geometry
	localparam int NUM_TIMERS_DEF = 6;
	localparam int IRQ_W          = 6;
	localparam int CNT_W          = 32;
	localparam int OFF_W          = 8;
	localparam int OP_W           = 2;
	localparam int TMR_IDX_W      = 3;

	localparam logic [OFF_W-1:0] BANK_BASE    = 8'h30;
	localparam logic [4:0]       LAST_REG_OFF = 5'h0c;
	localparam logic [CNT_W-1:0] ALL_ONES     = 32'hffff_ffff;

	// operation codes
	localparam logic [OP_W-1:0] OP_READ  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

	// register index within one timer
	localparam logic [1:0] REG_START  = 2'd0;
	localparam logic [1:0] REG_RELOAD = 2'd1;
	localparam logic [1:0] REG_COUNT  = 2'd2;
	localparam logic [1:0] REG_CTRL   = 2'd3;

	// control byte bit positions
	localparam int FLAG_BIT   = 1;
	localparam int ENABLE_BIT = 0;

	// per-timer command strobes
	typedef struct packed {
		logic wr_start;
		logic wr_reload;
		logic wr_count;
		logic wr_ctrl;
		logic tick;
	} tmr_cmd_t;

	// per-timer state as seen by the bus side
	typedef struct packed {
		logic             running;
		logic [CNT_W-1:0] reload;
		logic [CNT_W-1:0] count;
		logic             flag;
		logic             enable;
		logic             irq_d;
	} tmr_stat_t;

endpackage

`default_nettype wire

// ===== hdl/rdtb_timer.sv =====
// rdtb_timer: one 32-bit down-counting timer with reload, underflow flag and irq enable
// depends on rdtb_pkg
`default_nettype none

module rdtb_timer (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire rdtb_pkg::tmr_cmd_t cmd,
	input  wire [rdtb_pkg::CNT_W-1:0] wdata,
	output rdtb_pkg::tmr_stat_t     stat
);

	logic                       running_q, running_d;
	logic [rdtb_pkg::CNT_W-1:0] reload_q, reload_d;
	logic [rdtb_pkg::CNT_W-1:0] count_q, count_d;
	logic                       flag_q, flag_d;
	logic                       enable_q, enable_d;
	logic [rdtb_pkg::CNT_W-1:0] count_dec;

	assign count_dec = count_q - rdtb_pkg::CNT_W'(1);

	always_comb begin
		running_d = running_q;
		reload_d  = reload_q;
		count_d   = count_q;
		flag_d    = flag_q;
		enable_d  = enable_q;
		if (cmd.wr_start) begin
			running_d = wdata[0];
		end
		if (cmd.wr_reload) begin
			reload_d = wdata;
		end
		if (cmd.wr_count) begin
			count_d = wdata;
		end
		if (cmd.wr_ctrl) begin
			// flag can only be cleared from the bus
			flag_d   = flag_q & wdata[rdtb_pkg::FLAG_BIT];
			enable_d = wdata[rdtb_pkg::ENABLE_BIT];
		end
		if (cmd.tick && running_q) begin
			// count of 0 or 1 wraps through the reload value
			if (count_q[rdtb_pkg::CNT_W-1:1] == '0) begin
				count_d = count_dec + reload_q;
				flag_d  = 1'b1;
			end else begin
				count_d = count_dec;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			reload_q  <= rdtb_pkg::ALL_ONES;
			count_q   <= rdtb_pkg::ALL_ONES;
			flag_q    <= 1'b0;
			enable_q  <= 1'b0;
		end else begin
			running_q <= running_d;
			reload_q  <= reload_d;
			count_q   <= count_d;
			flag_q    <= flag_d;
			enable_q  <= enable_d;
		end
	end

	assign stat.running = running_q;
	assign stat.reload  = reload_q;
	assign stat.count   = count_q;
	assign stat.flag    = flag_q;
	assign stat.enable  = enable_q;
	assign stat.irq_d   = flag_d & enable_d;

endmodule

`default_nettype wire

// ===== hdl/reload_down_timer_bank.sv =====
// reload_down_timer_bank: each accepted input word passes the input register, then the
// result register; one word per clock, reads, writes and ticks alike, unless m_tready
// stalls; all timers step together; the only loop is the update of each timer register
// set; m_tready stalls the result register and through it the input register
// arst_n clears all timers (stopped, reload and count all ones, flag and enable low)
// and empties both pipeline registers
`default_nettype none

module reload_down_timer_bank #(
	parameter int NUM_TIMERS = rdtb_pkg::NUM_TIMERS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	// input words
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,   // [7:0] offset, [39:8] write_data
	input  wire  [1:0]  s_tuser,   // [1:0] operation
	// result words
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata    // [31:0] read_data, [37:32] irq_lines, [39:38] zero
);

	localparam int CNT_W = rdtb_pkg::CNT_W;
	localparam int OFF_W = rdtb_pkg::OFF_W;
	localparam int IRQ_W = rdtb_pkg::IRQ_W;

	// input register, stage 1
	logic                          valid_s1;
	logic [rdtb_pkg::OP_W-1:0]     op_s1;
	logic [OFF_W-1:0]              off_s1;
	logic [CNT_W-1:0]              wd_s1;

	// result register, stage 2
	logic                          valid_s2;
	logic [CNT_W-1:0]              rd_s2;
	logic [IRQ_W-1:0]              irq_s2;

	logic                          advance;
	logic [OFF_W-1:0]              rel;
	logic                          mapped;
	logic [rdtb_pkg::TMR_IDX_W-1:0] tmr_idx;
	logic [1:0]                    reg_idx;

	rdtb_pkg::tmr_cmd_t            cmd   [NUM_TIMERS];
	rdtb_pkg::tmr_stat_t           stat  [NUM_TIMERS];
	logic [CNT_W-1:0]              rd_lane [NUM_TIMERS];
	logic [CNT_W-1:0]              rd_d;
	logic [IRQ_W-1:0]              irq_d;

	// stage 1 moves into stage 2 when the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1  <= s_tuser;
			off_s1 <= s_tdata[OFF_W-1:0];
			wd_s1  <= s_tdata[OFF_W +: CNT_W];
		end
	end

	// offset decode: four word registers at the low end of each 0x20 window
	assign rel     = off_s1 - rdtb_pkg::BANK_BASE;
	assign mapped  = (off_s1 >= rdtb_pkg::BANK_BASE) && (rel[1:0] == 2'b00)
		&& (rel[4:0] <= rdtb_pkg::LAST_REG_OFF);
	assign tmr_idx = rel[7:5];
	assign reg_idx = rel[3:2];

	genvar n;
	generate
		for (n = 0; n < NUM_TIMERS; n++) begin : g_tmr
			logic hit;
			logic wr;

			assign hit = mapped && (tmr_idx == rdtb_pkg::TMR_IDX_W'(n));
			assign wr  = advance && (op_s1 == rdtb_pkg::OP_WRITE) && hit;

			// strobes only fire as the word leaves stage 1, so a stall changes nothing
			assign cmd[n].wr_start  = wr && (reg_idx == rdtb_pkg::REG_START);
			assign cmd[n].wr_reload = wr && (reg_idx == rdtb_pkg::REG_RELOAD);
			assign cmd[n].wr_count  = wr && (reg_idx == rdtb_pkg::REG_COUNT);
			assign cmd[n].wr_ctrl   = wr && (reg_idx == rdtb_pkg::REG_CTRL);
			assign cmd[n].tick      = advance && (op_s1 == rdtb_pkg::OP_TICK);

			rdtb_timer u_timer (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (cmd[n]),
				.wdata  (wd_s1),
				.stat   (stat[n])
			);

			// read value of this timer, zero when not addressed
			always_comb begin
				rd_lane[n] = '0;
				if ((op_s1 == rdtb_pkg::OP_READ) && hit) begin
					unique case (reg_idx)
						rdtb_pkg::REG_START:  rd_lane[n] = CNT_W'(stat[n].running);
						rdtb_pkg::REG_RELOAD: rd_lane[n] = stat[n].reload;
						rdtb_pkg::REG_COUNT:  rd_lane[n] = stat[n].count;
						rdtb_pkg::REG_CTRL:   rd_lane[n] = CNT_W'({stat[n].flag, stat[n].enable});
						default:              rd_lane[n] = '0;
					endcase
				end
			end

			// interrupt lines exist for the first six timers only
			if (n < IRQ_W) begin : g_irq
				assign irq_d[n] = stat[n].irq_d;
			end
		end

		for (n = NUM_TIMERS; n < IRQ_W; n++) begin : g_irq_pad
			assign irq_d[n] = 1'b0;
		end
	endgenerate

	// at most one lane is addressed, so an or over the lanes is the read mux
	always_comb begin
		rd_d = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			rd_d = rd_d | rd_lane[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	// irq lines are taken after the word has been applied
	always_ff @(posedge clk) begin
		if (advance) begin
			rd_s2  <= rd_d;
			irq_s2 <= irq_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, irq_s2, rd_s2};

endmodule

`default_nettype wire

// ===== test/rdtb_checker.sv =====
// rdtb_checker: watches both streams of the reload down-timer bank, predicts every result word
// from a private copy of the six timers and compares it field by field; uses rdtb_pkg
`default_nettype none

module rdtb_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [39:0] s_tdata,   // [7:0] offset, [39:8] write_data
	input  wire  [1:0]  s_tuser,   // [1:0] operation
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [39:0] m_tdata,   // [31:0] read_data, [37:32] irq_lines, [39:38] zero
	output int          fail_count,
	output int          outstanding,
	output int          results_checked,
	output int          underflows
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [rdtb_pkg::CNT_W-1:0] read_data;
		logic [rdtb_pkg::IRQ_W-1:0] irq_lines;
	} timer_result_t;

	// private copy of the bank
	logic                       tmr_running [rdtb_pkg::NUM_TIMERS_DEF];
	logic [rdtb_pkg::CNT_W-1:0] tmr_reload  [rdtb_pkg::NUM_TIMERS_DEF];
	logic [rdtb_pkg::CNT_W-1:0] tmr_count   [rdtb_pkg::NUM_TIMERS_DEF];
	logic                       tmr_flag    [rdtb_pkg::NUM_TIMERS_DEF];
	logic                       tmr_enable  [rdtb_pkg::NUM_TIMERS_DEF];

	timer_result_t expected_words[$];

	// applies one bus access or tick to the bank copy and returns the word it produces
	function automatic timer_result_t bank_step(input logic [rdtb_pkg::OP_W-1:0] op,
			input logic [rdtb_pkg::OFF_W-1:0] off, input logic [rdtb_pkg::CNT_W-1:0] wd);
		timer_result_t              res;
		logic [rdtb_pkg::OFF_W-1:0] rel;
		logic [2:0]                 tmr;
		logic [1:0]                 rsel;
		logic                       mapped;
		res = '0;
		rel = off - rdtb_pkg::BANK_BASE;
		tmr = rel[7:5];
		rsel = rel[3:2];
		mapped = (off >= rdtb_pkg::BANK_BASE) && (rel[1:0] == 2'b00)
			&& (rel[4:0] <= rdtb_pkg::LAST_REG_OFF)
			&& (int'(tmr) < rdtb_pkg::NUM_TIMERS_DEF);
		if (op == rdtb_pkg::OP_READ && mapped) begin
			case (rsel)
				rdtb_pkg::REG_START:  res.read_data = {31'd0, tmr_running[tmr]};
				rdtb_pkg::REG_RELOAD: res.read_data = tmr_reload[tmr];
				rdtb_pkg::REG_COUNT:  res.read_data = tmr_count[tmr];
				default:    res.read_data = {30'd0, tmr_flag[tmr], tmr_enable[tmr]};
			endcase
		end else if (op == rdtb_pkg::OP_WRITE && mapped) begin
			case (rsel)
				rdtb_pkg::REG_START:  tmr_running[tmr] = wd[0];
				rdtb_pkg::REG_RELOAD: tmr_reload[tmr] = wd;
				rdtb_pkg::REG_COUNT:  tmr_count[tmr] = wd;
				default: begin
					// flag can only be cleared from the bus
					tmr_flag[tmr] = tmr_flag[tmr] & wd[rdtb_pkg::FLAG_BIT];
					tmr_enable[tmr] = wd[rdtb_pkg::ENABLE_BIT];
				end
			endcase
		end else if (op == rdtb_pkg::OP_TICK) begin
			for (int n = 0; n < rdtb_pkg::NUM_TIMERS_DEF; n++) begin
				if (tmr_running[n]) begin
					if (tmr_count[n] <= 1) begin
						tmr_count[n] = tmr_count[n] - 1 + tmr_reload[n];
						tmr_flag[n] = 1'b1;
						underflows++;
					end else begin
						tmr_count[n] = tmr_count[n] - 1;
					end
				end
			end
		end
		for (int n = 0; n < rdtb_pkg::NUM_TIMERS_DEF; n++)
			res.irq_lines[n] = tmr_flag[n] & tmr_enable[n];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		timer_result_t want;
		if (!arst_n) begin
			for (int n = 0; n < rdtb_pkg::NUM_TIMERS_DEF; n++) begin
				tmr_running[n] = 1'b0;
				tmr_reload[n] = rdtb_pkg::ALL_ONES;
				tmr_count[n] = rdtb_pkg::ALL_ONES;
				tmr_flag[n] = 1'b0;
				tmr_enable[n] = 1'b0;
			end
			expected_words.delete();
			fail_count = 0;
			outstanding = 0;
			results_checked = 0;
			underflows = 0;
		end else begin
			// results first: a word accepted now cannot come out at the same edge
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected result word %h", m_tdata);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (m_tdata[31:0] !== want.read_data) begin
						$error("read_data: expected %h, got %h", want.read_data, m_tdata[31:0]);
						fail_count++;
					end
					if (m_tdata[37:32] !== want.irq_lines) begin
						$error("irq_lines: expected %h, got %h", want.irq_lines, m_tdata[37:32]);
						fail_count++;
					end
					if (m_tdata[39:38] !== 2'b00) begin
						$error("pad: expected %h, got %h", 2'b00, m_tdata[39:38]);
						fail_count++;
					end
				end
				results_checked++;
			end
			if (s_tvalid && s_tready)
				expected_words.push_back(bank_step(s_tuser, s_tdata[7:0], s_tdata[39:8]));
			outstanding = expected_words.size();
		end
	end

endmodule

`default_nettype wire

// ===== test/reload_down_timer_bank_tb.sv =====
// reload_down_timer_bank_tb: drives register reads, writes and ticks into the timer bank
// with random idling on both streams; depends on rdtb_pkg, the block and rdtb_checker
`default_nettype none

module reload_down_timer_bank_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 100000;  // far above the slowest run
	localparam int RANDOM_WORDS = 580;
	localparam int CALM_FROM    = 480;     // no idling from this random word on

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // [7:0] offset, [39:8] write_data
	logic [1:0]  s_tuser;   // [1:0] operation
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [31:0] read_data, [37:32] irq_lines, [39:38] zero

	int fail_count;
	int outstanding;
	int results_checked;
	int underflows;

	// idling controls: calm is shared by source and sink, gap_pct drives the source only
	logic calm;
	int   gap_pct;

	reload_down_timer_bank u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	rdtb_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.underflows      (underflows)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// byte offset of register rsel of timer t
	function automatic logic [rdtb_pkg::OFF_W-1:0] reg_offset(input int t,
			input logic [1:0] rsel);
		return rdtb_pkg::BANK_BASE + rdtb_pkg::OFF_W'(t * 32) + {4'd0, rsel, 2'b00};
	endfunction

	// hold one word on the input stream until it is taken, then maybe idle a while
	task automatic send_word(input logic [rdtb_pkg::OP_W-1:0] op,
			input logic [rdtb_pkg::OFF_W-1:0] off, input logic [rdtb_pkg::CNT_W-1:0] wd);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {wd, off};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// mostly well-formed accesses aimed at small counts so that underflows happen often
	task automatic send_random_word();
		int                         pick;
		int                         t;
		logic [1:0]                 rsel;
		logic [rdtb_pkg::CNT_W-1:0] wd;
		pick = $urandom_range(0, 99);
		t = $urandom_range(0, rdtb_pkg::NUM_TIMERS_DEF - 1);
		rsel = 2'($urandom_range(0, 3));
		wd = $urandom();
		if (pick < 38) begin
			// tick; offset and data are don't-care but still toggled
			send_word(rdtb_pkg::OP_TICK, rdtb_pkg::OFF_W'($urandom()), wd);
		end else if (pick < 70) begin
			case (rsel)
				rdtb_pkg::REG_START: begin
					// keep most timers running
					if ($urandom_range(0, 3) != 0)
						wd[0] = 1'b1;
				end
				rdtb_pkg::REG_RELOAD: begin
					if ($urandom_range(0, 2) != 0)
						wd = $urandom_range(0, 6);
				end
				rdtb_pkg::REG_COUNT: begin
					if ($urandom_range(0, 3) != 0)
						wd = $urandom_range(0, 5);
				end
				default: ;
			endcase
			send_word(rdtb_pkg::OP_WRITE, reg_offset(t, rsel), wd);
		end else if (pick < 90) begin
			send_word(rdtb_pkg::OP_READ, reg_offset(t, rsel), wd);
		end else begin
			// noise: any operation code, any offset
			send_word(2'($urandom_range(0, 3)), rdtb_pkg::OFF_W'($urandom()), wd);
		end
	endtask

	// result side: ready in random stretches broken by short stalls
	initial begin : sink
		int n;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			m_tready <= 1'b1;
			n = $urandom_range(1, 20);
			repeat (n) @(posedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		calm = 1'b0;
		gap_pct = 30;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= rdtb_pkg::OP_READ;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset contents and the unmapped corners of the map
		send_word(rdtb_pkg::OP_READ, reg_offset(0, rdtb_pkg::REG_START), 32'h0);
		send_word(rdtb_pkg::OP_READ, reg_offset(0, rdtb_pkg::REG_RELOAD), 32'h0);
		send_word(rdtb_pkg::OP_READ, reg_offset(5, rdtb_pkg::REG_COUNT), 32'hffff_ffff);
		send_word(rdtb_pkg::OP_READ, reg_offset(5, rdtb_pkg::REG_CTRL), 32'h0);
		send_word(rdtb_pkg::OP_READ, 8'h00, 32'h0);
		send_word(rdtb_pkg::OP_READ, 8'hff, 32'hffff_ffff);
		send_word(rdtb_pkg::OP_READ, 8'h31, 32'h0);          // misaligned
		send_word(rdtb_pkg::OP_READ, 8'h40, 32'h0);          // hole after timer 0 control
		// timer past the bank, ignored
		send_word(rdtb_pkg::OP_WRITE, reg_offset(6, rdtb_pkg::REG_COUNT), 32'h0);
		send_word(rdtb_pkg::OP_READ, reg_offset(6, rdtb_pkg::REG_COUNT), 32'h0);
		// unknown operation
		send_word(2'd3, reg_offset(0, rdtb_pkg::REG_COUNT), 32'hffff_ffff);

		// zero reload: count runs 2, 1, 0, then wraps to all ones
		send_word(rdtb_pkg::OP_WRITE, reg_offset(1, rdtb_pkg::REG_RELOAD), 32'h0);
		send_word(rdtb_pkg::OP_WRITE, reg_offset(1, rdtb_pkg::REG_COUNT), 32'd2);
		send_word(rdtb_pkg::OP_WRITE, reg_offset(1, rdtb_pkg::REG_CTRL), 32'h3);
		send_word(rdtb_pkg::OP_WRITE, reg_offset(1, rdtb_pkg::REG_START), 32'hffff_ffff);
		send_word(rdtb_pkg::OP_TICK, 8'h00, 32'h0);
		send_word(rdtb_pkg::OP_TICK, 8'h00, 32'h0);
		send_word(rdtb_pkg::OP_TICK, 8'h00, 32'h0);
		send_word(rdtb_pkg::OP_READ, reg_offset(1, rdtb_pkg::REG_CTRL), 32'h0);

		// flag survives a write with bit1 set, cleared by one without
		send_word(rdtb_pkg::OP_WRITE, reg_offset(1, rdtb_pkg::REG_CTRL), 32'h3);
		send_word(rdtb_pkg::OP_WRITE, reg_offset(1, rdtb_pkg::REG_CTRL), 32'h1);

		// count rewrite while running, then stop the timer
		send_word(rdtb_pkg::OP_WRITE, reg_offset(1, rdtb_pkg::REG_COUNT), 32'h0);
		send_word(rdtb_pkg::OP_TICK, 8'h00, 32'h0);
		send_word(rdtb_pkg::OP_WRITE, reg_offset(1, rdtb_pkg::REG_START), 32'h0);
		send_word(rdtb_pkg::OP_TICK, 8'h00, 32'h0);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			// idling density is picked anew every 60 words, some stretches have none
			if (i % 60 == 0)
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 20;
					default: gap_pct = 50;
				endcase
			if (i == CALM_FROM)
				calm = 1'b1;
			send_random_word();
		end
		s_tvalid <= 1'b0;

		wait (outstanding == 0);
		repeat (10) @(posedge clk);

		$display("checked %0d result words over reads, writes, ticks and unmapped accesses",
			results_checked);
		$display("timer underflows predicted along the way: %0d", underflows);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
